// File: src/ppu_rvp_pkg.sv
// Shared types, command codes and address helpers for the picture-processor register port.
package ppu_rvp_pkg;

    localparam int PATTERN_BYTES_DEF = 8192;
    localparam int NAME_BYTES        = 4096;
    localparam int PALETTE_ENTRIES   = 32;
    localparam int QUEUE_DEPTH       = 2;

    // Command codes of the request channel.
    localparam logic [2:0] CMD_REG_WR       = 3'd0;
    localparam logic [2:0] CMD_REG_RD       = 3'd1;
    localparam logic [2:0] CMD_OAM_LOAD     = 3'd2;
    localparam logic [2:0] CMD_VRAM_LOAD    = 3'd3;
    localparam logic [2:0] CMD_FRAME_START  = 3'd4;
    localparam logic [2:0] CMD_RAISE_STATUS = 3'd5;

    // CPU register numbers.
    localparam logic [2:0] REG_CTRL_A   = 3'd0;
    localparam logic [2:0] REG_CTRL_B   = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_SPR_ADDR = 3'd3;
    localparam logic [2:0] REG_SPR_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // Name-table mirroring modes.
    localparam logic [2:0] MIRROR_SINGLE_LO = 3'd0;
    localparam logic [2:0] MIRROR_SINGLE_HI = 3'd1;
    localparam logic [2:0] MIRROR_VERT  = 3'd2;
    localparam logic [2:0] MIRROR_HORZ  = 3'd3;
    localparam logic [2:0] MIRROR_FOUR  = 3'd4;
    localparam logic [2:0] MIRROR_RESET = MIRROR_HORZ;

    localparam logic [14:0] NAME_BASE    = 15'h2000;
    localparam logic [14:0] PALETTE_BASE = 15'h3f00;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  reg_index;
        logic [7:0]  data;
        logic [14:0] load_addr;
        logic [2:0]  status_flags;
        logic        vram_read;
    } t_item;

    typedef struct packed {
        logic clearing;
        logic pop;
    } t_back_stat;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_FETCH,
        ST_EXEC
    } t_back_state;

    function automatic logic [11:0] name_index(input logic [14:0] addr,
                                               input logic [2:0]  mode);
        logic [1:0] quarter;
        logic [1:0] bank;
        quarter = addr[11:10];
        unique case (mode)
            MIRROR_VERT: bank = {1'b0, quarter[0]};
            MIRROR_HORZ: bank = {1'b0, quarter[1]};
            MIRROR_FOUR: bank = quarter;
            default:     bank = {1'b0, mode[0]};
        endcase
        return {bank, addr[9:0]};
    endfunction

endpackage

// File: src/ppu_register_vram_port.sv
// Top level of the picture-processor register port.
// Each request passes through the back-end states FETCH and EXEC: FETCH issues
// the registered read of the pattern or name-table memory at v, EXEC waits while
// a held result is not taken, then updates the registers, writes the memories
// and loads the result register. The two-entry queue and the result register
// let requests arrive while a result waits or an earlier request executes.
// After reset the pattern and name-table memories are cleared in a single pass,
// during which no request is accepted; configuration writes are taken at any time.
// Sprite memory contents cannot be read back through this port and are not stored.
module ppu_register_vram_port #(
    parameter int PATTERN_BYTES = ppu_rvp_pkg::PATTERN_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [2:0]  i_reg_index,
    input  logic [7:0]  i_data,
    input  logic [14:0] i_load_addr,
    input  logic [2:0]  i_status_flags,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_nmi_request,
    output logic [14:0] o_scroll_v,
    output logic [2:0]  o_fine_x_out
);

    ppu_rvp_pkg::t_back_stat stat;
    ppu_rvp_pkg::t_item      q_item;
    logic                    q_valid;

    ppu_rvp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_reg_index    (i_reg_index),
        .i_data         (i_data),
        .i_load_addr    (i_load_addr),
        .i_status_flags (i_status_flags),
        .i_stat         (stat),
        .o_q_valid      (q_valid),
        .o_q_item       (q_item)
    );

    ppu_rvp_back #(
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_data   (o_read_data),
        .o_nmi_request (o_nmi_request),
        .o_scroll_v    (o_scroll_v),
        .o_fine_x_out  (o_fine_x_out)
    );

`ifndef ASSERT_OFF
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> !o_in_ready)
        else $error("request accepted during memory clearing pass");

    a_clear_runs_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !stat.clearing |=> !stat.clearing)
        else $error("clearing pass restarted without reset");

    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.pop |-> q_valid)
        else $error("back end executed with an empty request queue");

    a_pop_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.pop |=> o_out_valid)
        else $error("executed request produced no result");
`endif

endmodule

// File: src/ppu_rvp_front.sv
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
module ppu_rvp_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [2:0]              i_cmd,
    input  logic [2:0]              i_reg_index,
    input  logic [7:0]              i_data,
    input  logic [14:0]             i_load_addr,
    input  logic [2:0]              i_status_flags,
    input  ppu_rvp_pkg::t_back_stat i_stat,
    output logic                    o_q_valid,
    output ppu_rvp_pkg::t_item      o_q_item
);

    ppu_rvp_pkg::t_item r_slot [ppu_rvp_pkg::QUEUE_DEPTH];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;
    logic [1:0]         n_count;
    logic               push;
    logic               pop;
    ppu_rvp_pkg::t_item item;

    always_comb begin
        item.cmd          = i_cmd;
        item.reg_index    = i_reg_index;
        item.data         = i_data;
        item.load_addr    = i_load_addr;
        item.status_flags = i_status_flags;
        // Only a data-register read needs the registered memory read.
        item.vram_read    = (i_cmd == ppu_rvp_pkg::CMD_REG_RD)
                         && (i_reg_index == ppu_rvp_pkg::REG_DATA);
    end

    assign o_in_ready = (r_count != 2'(ppu_rvp_pkg::QUEUE_DEPTH)) && !i_stat.clearing;
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_stat.pop && (r_count != 2'd0);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= item;
        end
    end

endmodule

// File: src/ppu_rvp_back.sv
// Back end: register state, video memories and the result register.
module ppu_rvp_back #(
    parameter int PATTERN_BYTES = ppu_rvp_pkg::PATTERN_BYTES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_wdata,
    input  logic                    i_q_valid,
    input  ppu_rvp_pkg::t_item      i_q_item,
    output ppu_rvp_pkg::t_back_stat o_stat,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [7:0]              o_read_data,
    output logic                    o_nmi_request,
    output logic [14:0]             o_scroll_v,
    output logic [2:0]              o_fine_x_out
);

    localparam int              PAT_AW   = $clog2(PATTERN_BYTES);
    localparam logic [13:0]     PAT_SIZE = 14'(PATTERN_BYTES);
    localparam logic [PAT_AW-1:0] PAT_LAST = PAT_AW'(PATTERN_BYTES - 1);

    ppu_rvp_pkg::t_back_state r_state, n_state;
    logic [PAT_AW-1:0] r_clr_cnt;

    logic [14:0] r_v, n_v;
    logic [14:0] r_t, n_t;
    logic [2:0]  r_fine_x, n_fine_x;
    logic        r_toggle, n_toggle;
    logic [7:0]  r_rbuf, n_rbuf;
    logic [2:0]  r_status, n_status;
    logic [7:0]  r_ctrl_a, n_ctrl_a;
    logic [7:0]  r_ctrl_b, n_ctrl_b;
    logic [7:0]  r_spr_addr, n_spr_addr;
    logic [2:0]  r_mirror;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_rd, n_rd;
    logic        r_nmi, n_nmi;

    logic [7:0]  r_pat_mem  [PATTERN_BYTES];
    logic [7:0]  r_name_mem [ppu_rvp_pkg::NAME_BYTES];
    logic [5:0]  r_pal      [ppu_rvp_pkg::PALETTE_ENTRIES];
    logic [7:0]  r_pat_q;
    logic [7:0]  r_name_q;

    logic              exec_go;
    logic              mem_re;
    logic              pat_we;
    logic [PAT_AW-1:0] pat_wa;
    logic              name_we;
    logic [11:0]       name_wa;
    logic [7:0]        mem_wd;
    logic              pal_we;
    logic              vram_we;
    logic [14:0]       wr_addr;
    logic [14:0]       inc;
    logic [7:0]        fetched;
    logic [14:0]       t_scroll;

    function automatic logic [PAT_AW-1:0] pat_index(input logic [14:0] addr);
        logic [13:0] a;
        a = {1'b0, addr[12:0]};
        if (a >= PAT_SIZE) begin
            a = a - PAT_SIZE;
        end
        return a[PAT_AW-1:0];
    endfunction

    assign exec_go = (r_state == ppu_rvp_pkg::ST_EXEC) && (!r_out_valid || i_out_ready);
    assign mem_re  = (r_state == ppu_rvp_pkg::ST_FETCH) && i_q_valid && i_q_item.vram_read;
    assign inc     = r_ctrl_a[2] ? 15'd32 : 15'd1;

    assign o_stat.clearing = (r_state == ppu_rvp_pkg::ST_CLEAR);
    assign o_stat.pop      = exec_go;

    // v and fine x only change when a new result is loaded, so they track the held result.
    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_rd;
    assign o_nmi_request = r_nmi;
    assign o_scroll_v    = r_v;
    assign o_fine_x_out  = r_fine_x;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppu_rvp_pkg::ST_CLEAR: begin
                if (r_clr_cnt == PAT_LAST) begin
                    n_state = ppu_rvp_pkg::ST_FETCH;
                end
            end
            ppu_rvp_pkg::ST_FETCH: begin
                if (i_q_valid) begin
                    n_state = ppu_rvp_pkg::ST_EXEC;
                end
            end
            ppu_rvp_pkg::ST_EXEC: begin
                if (exec_go) begin
                    n_state = ppu_rvp_pkg::ST_FETCH;
                end
            end
            default: n_state = ppu_rvp_pkg::ST_FETCH;
        endcase
    end

    always_comb begin
        if (r_v < ppu_rvp_pkg::NAME_BASE) begin
            fetched = r_pat_q;
        end else if (r_v < ppu_rvp_pkg::PALETTE_BASE) begin
            fetched = r_name_q;
        end else begin
            fetched = {2'b00, r_pal[r_v[4:0]]};
        end
    end

    always_comb begin
        n_v         = r_v;
        n_t         = r_t;
        n_fine_x    = r_fine_x;
        n_toggle    = r_toggle;
        n_rbuf      = r_rbuf;
        n_status    = r_status;
        n_ctrl_a    = r_ctrl_a;
        n_ctrl_b    = r_ctrl_b;
        n_spr_addr  = r_spr_addr;
        n_out_valid = r_out_valid;
        n_rd        = r_rd;
        n_nmi       = r_nmi;
        vram_we     = 1'b0;
        wr_addr     = r_v;
        mem_wd      = i_q_item.data;
        t_scroll    = r_t;

        if (exec_go) begin
            n_out_valid = 1'b1;
            n_rd        = 8'd0;
            n_nmi       = 1'b0;
            unique case (i_q_item.cmd)
                ppu_rvp_pkg::CMD_REG_WR: begin
                    unique case (i_q_item.reg_index)
                        ppu_rvp_pkg::REG_CTRL_A:   n_ctrl_a = i_q_item.data;
                        ppu_rvp_pkg::REG_CTRL_B:   n_ctrl_b = i_q_item.data;
                        ppu_rvp_pkg::REG_SPR_ADDR: n_spr_addr = i_q_item.data;
                        ppu_rvp_pkg::REG_SPR_DATA: n_spr_addr = r_spr_addr + 8'd1;
                        ppu_rvp_pkg::REG_SCROLL: begin
                            if (r_toggle) begin
                                n_t = (r_t & 15'h0c1f)
                                    | {i_q_item.data[2:0], 12'd0}
                                    | {5'd0, i_q_item.data[7:3], 5'd0};
                                n_toggle = 1'b0;
                            end else begin
                                n_fine_x = i_q_item.data[2:0];
                                n_t      = (r_t & 15'h7fe0) | {10'd0, i_q_item.data[7:3]};
                                n_toggle = 1'b1;
                            end
                        end
                        ppu_rvp_pkg::REG_ADDR: begin
                            if (r_toggle) begin
                                t_scroll = (r_t & 15'h7f00) | {7'd0, i_q_item.data};
                                n_t      = t_scroll;
                                n_v      = t_scroll;
                                n_toggle = 1'b0;
                            end else begin
                                n_t      = (r_t & 15'h00ff) | {1'b0, i_q_item.data[5:0], 8'd0};
                                n_toggle = 1'b1;
                            end
                        end
                        ppu_rvp_pkg::REG_DATA: begin
                            vram_we = 1'b1;
                            n_v     = r_v + inc;
                        end
                        default: ;
                    endcase
                end
                ppu_rvp_pkg::CMD_REG_RD: begin
                    unique case (i_q_item.reg_index)
                        ppu_rvp_pkg::REG_STATUS: begin
                            n_rd        = {r_status, 5'd0};
                            n_status[2] = 1'b0;
                            n_toggle    = 1'b0;
                        end
                        ppu_rvp_pkg::REG_DATA: begin
                            // Palette reads skip the delay through the buffer.
                            n_rd   = (r_v >= ppu_rvp_pkg::PALETTE_BASE) ? fetched : r_rbuf;
                            n_rbuf = fetched;
                            n_v    = r_v + inc;
                        end
                        default: ;
                    endcase
                end
                ppu_rvp_pkg::CMD_VRAM_LOAD: begin
                    vram_we = 1'b1;
                    wr_addr = i_q_item.load_addr;
                end
                ppu_rvp_pkg::CMD_FRAME_START: begin
                    n_status = 3'd0;
                    if (r_ctrl_b[4:3] != 2'b00) begin
                        n_v = (r_t & 15'h73ff) | {3'd0, r_ctrl_a[1:0], 10'd0};
                    end
                end
                ppu_rvp_pkg::CMD_RAISE_STATUS: begin
                    n_status = r_status | i_q_item.status_flags;
                    n_nmi    = i_q_item.status_flags[2] & r_ctrl_a[7];
                end
                default: ;
            endcase
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        pat_we  = 1'b0;
        name_we = 1'b0;
        pal_we  = 1'b0;
        pat_wa  = pat_index(wr_addr);
        name_wa = ppu_rvp_pkg::name_index(wr_addr, r_mirror);
        if (r_state == ppu_rvp_pkg::ST_CLEAR) begin
            pat_we  = 1'b1;
            name_we = 1'b1;
            pat_wa  = r_clr_cnt;
            name_wa = r_clr_cnt[11:0];
        end else if (vram_we) begin
            if (wr_addr < ppu_rvp_pkg::NAME_BASE) begin
                pat_we = 1'b1;
            end else if (wr_addr < ppu_rvp_pkg::PALETTE_BASE) begin
                name_we = 1'b1;
            end else begin
                pal_we = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            r_pat_mem[pat_wa] <= (r_state == ppu_rvp_pkg::ST_CLEAR) ? 8'd0 : mem_wd;
        end
        if (mem_re) begin
            r_pat_q <= r_pat_mem[pat_index(r_v)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (name_we) begin
            r_name_mem[name_wa] <= (r_state == ppu_rvp_pkg::ST_CLEAR) ? 8'd0 : mem_wd;
        end
        if (mem_re) begin
            r_name_q <= r_name_mem[ppu_rvp_pkg::name_index(r_v, r_mirror)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ppu_rvp_pkg::PALETTE_ENTRIES; i++) begin
                r_pal[i] <= 6'd0;
            end
        end else if (pal_we) begin
            if (wr_addr[1:0] != 2'b00) begin
                r_pal[wr_addr[4:0]] <= mem_wd[5:0];
            end else begin
                // Entries at multiples of four are shared between the two halves.
                r_pal[{1'b0, wr_addr[3:0]}] <= mem_wd[5:0];
                r_pal[{1'b1, wr_addr[3:0]}] <= mem_wd[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppu_rvp_pkg::ST_CLEAR;
            r_clr_cnt   <= '0;
            r_v         <= 15'd0;
            r_t         <= 15'd0;
            r_fine_x    <= 3'd0;
            r_toggle    <= 1'b0;
            r_rbuf      <= 8'd0;
            r_status    <= 3'd0;
            r_ctrl_a    <= 8'd0;
            r_ctrl_b    <= 8'd0;
            r_spr_addr  <= 8'd0;
            r_mirror    <= ppu_rvp_pkg::MIRROR_RESET;
            r_out_valid <= 1'b0;
            r_rd        <= 8'd0;
            r_nmi       <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (r_state == ppu_rvp_pkg::ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + PAT_AW'(1);
            end
            r_v         <= n_v;
            r_t         <= n_t;
            r_fine_x    <= n_fine_x;
            r_toggle    <= n_toggle;
            r_rbuf      <= n_rbuf;
            r_status    <= n_status;
            r_ctrl_a    <= n_ctrl_a;
            r_ctrl_b    <= n_ctrl_b;
            r_spr_addr  <= n_spr_addr;
            if (i_cfg_we) begin
                r_mirror <= i_cfg_wdata;
            end
            r_out_valid <= n_out_valid;
            r_rd        <= n_rd;
            r_nmi       <= n_nmi;
        end
    end

endmodule

// File: tb/tb.sv
// Testbench for the picture-processor register port with directed and random requests.
`timescale 1ns / 100ps

module tb;

    localparam int PAT_BYTES   = 8192;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1850;

    typedef struct {
        logic [2:0]  cmd;
        logic [2:0]  idx;
        logic [7:0]  data;
        logic [14:0] addr;
        logic [2:0]  flags;
    } t_req;

    typedef struct {
        logic [7:0]  rd;
        logic        nmi;
        logic [14:0] v;
        logic [2:0]  fx;
    } t_resp;

    typedef struct {
        logic [2:0]  cmd;
        logic [2:0]  idx;
        logic [7:0]  data;
        logic [14:0] addr;
        logic [2:0]  flags;
        bit          chk;
        logic [7:0]  rd;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_cmd = '0;
    logic [2:0]  i_reg_index = '0;
    logic [7:0]  i_data = '0;
    logic [14:0] i_load_addr = '0;
    logic [2:0]  i_status_flags = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_nmi_request;
    logic [14:0] o_scroll_v;
    logic [2:0]  o_fine_x_out;

    // Predictor state.
    logic [2:0]  p_mirror;
    logic [14:0] p_v, p_t;
    logic [2:0]  p_fx;
    logic        p_toggle;
    logic [7:0]  p_buf;
    logic [2:0]  p_status;
    logic [7:0]  p_ctrl_a, p_ctrl_b, p_spr_addr;
    logic [7:0]  p_pattern [PAT_BYTES];
    logic [7:0]  p_names [4096];
    logic [5:0]  p_palette [32];

    t_resp expected_q[$];
    int    mismatches = 0;
    int    cycles = 0;
    bit    quiet = 1'b0;

    ppu_register_vram_port #(.PATTERN_BYTES(PAT_BYTES)) DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [11:0] mirrored(logic [14:0] a);
        logic [1:0] q;
        logic [1:0] bank;
        q = a[11:10];
        case (p_mirror)
            ppu_rvp_pkg::MIRROR_VERT: bank = {1'b0, q[0]};
            ppu_rvp_pkg::MIRROR_HORZ: bank = {1'b0, q[1]};
            ppu_rvp_pkg::MIRROR_FOUR: bank = q;
            default:                  bank = {1'b0, p_mirror[0]};
        endcase
        return {bank, a[9:0]};
    endfunction

    task automatic mem_store(logic [14:0] a, logic [7:0] val);
        if (a < ppu_rvp_pkg::NAME_BASE) p_pattern[a % PAT_BYTES] = val;
        else if (a < ppu_rvp_pkg::PALETTE_BASE) p_names[mirrored(a)] = val;
        else if (a[1:0] != 2'b00) p_palette[a[4:0]] = val[5:0];
        else begin
            p_palette[{1'b0, a[3:0]}] = val[5:0];
            p_palette[{1'b1, a[3:0]}] = val[5:0];
        end
    endtask

    function automatic logic [7:0] mem_fetch(logic [14:0] a);
        if (a < ppu_rvp_pkg::NAME_BASE) return p_pattern[a % PAT_BYTES];
        if (a < ppu_rvp_pkg::PALETTE_BASE) return p_names[mirrored(a)];
        return {2'b00, p_palette[a[4:0]]};
    endfunction

    function automatic void step_v();
        p_v = p_v + (p_ctrl_a[2] ? 15'd32 : 15'd1);
    endfunction

    task automatic predict_port_response(input t_req r, output t_resp o);
        o.rd = '0;
        o.nmi = 1'b0;
        case (r.cmd)
            ppu_rvp_pkg::CMD_REG_WR: begin
                case (r.idx)
                    ppu_rvp_pkg::REG_CTRL_A:   p_ctrl_a = r.data;
                    ppu_rvp_pkg::REG_CTRL_B:   p_ctrl_b = r.data;
                    ppu_rvp_pkg::REG_SPR_ADDR: p_spr_addr = r.data;
                    ppu_rvp_pkg::REG_SPR_DATA: p_spr_addr = p_spr_addr + 8'd1;
                    ppu_rvp_pkg::REG_SCROLL: begin
                        if (p_toggle)
                            p_t = (p_t & 15'h0c1f) | {r.data[2:0], 12'd0}
                                  | {5'd0, r.data[7:3], 5'd0};
                        else begin
                            p_fx = r.data[2:0];
                            p_t = (p_t & 15'h7fe0) | {10'd0, r.data[7:3]};
                        end
                        p_toggle = ~p_toggle;
                    end
                    ppu_rvp_pkg::REG_ADDR: begin
                        if (p_toggle) begin
                            p_t = (p_t & 15'h7f00) | {7'd0, r.data};
                            p_v = p_t;
                        end else
                            p_t = {1'b0, r.data[5:0], p_t[7:0]};
                        p_toggle = ~p_toggle;
                    end
                    ppu_rvp_pkg::REG_DATA: begin
                        mem_store(p_v, r.data);
                        step_v();
                    end
                    default: ;
                endcase
            end
            ppu_rvp_pkg::CMD_REG_RD: begin
                if (r.idx == ppu_rvp_pkg::REG_STATUS) begin
                    o.rd = {p_status, 5'd0};
                    p_status[2] = 1'b0;
                    p_toggle = 1'b0;
                end else if (r.idx == ppu_rvp_pkg::REG_DATA) begin
                    o.rd = p_buf;
                    p_buf = mem_fetch(p_v);
                    // Palette reads skip the delay of the buffer.
                    if (p_v >= ppu_rvp_pkg::PALETTE_BASE) o.rd = p_buf;
                    step_v();
                end
            end
            ppu_rvp_pkg::CMD_VRAM_LOAD: mem_store(r.addr, r.data);
            ppu_rvp_pkg::CMD_FRAME_START: begin
                p_status = '0;
                if (p_ctrl_b[4] || p_ctrl_b[3])
                    p_v = {p_t[14:12], p_ctrl_a[1:0], p_t[9:0]};
            end
            ppu_rvp_pkg::CMD_RAISE_STATUS: begin
                p_status = p_status | r.flags;
                o.nmi = r.flags[2] & p_ctrl_a[7];
            end
            default: ;
        endcase
        o.v = p_v;
        o.fx = p_fx;
    endtask

    // Drive one request, hold it until taken, and predict on acceptance.
    task automatic send_request(input t_req r, input bit chk, input logic [7:0] rd);
        t_resp o;
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= r.cmd;
        i_reg_index <= r.idx;
        i_data <= r.data;
        i_load_addr <= r.addr;
        i_status_flags <= r.flags;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        predict_port_response(r, o);
        if (chk) o.rd = rd;
        expected_q.push_back(o);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    always @(negedge i_clk)
        i_out_ready <= quiet || ($urandom_range(99) >= 22);

    always @(posedge i_clk) begin
        t_resp e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result at cycle %0d", cycles);
            end else begin
                e = expected_q.pop_front();
                if (o_read_data !== e.rd || o_nmi_request !== e.nmi
                        || o_scroll_v !== e.v || o_fine_x_out !== e.fx) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at cycle %0d: exp rd=%h nmi=%b v=%h fx=%0d,",
                                 cycles, e.rd, e.nmi, e.v, e.fx,
                                 " got rd=%h nmi=%b v=%h fx=%0d",
                                 o_read_data, o_nmi_request, o_scroll_v, o_fine_x_out);
                end
            end
        end
    end

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_mirror(logic [2:0] mode);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        p_mirror = mode;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_req random_request();
        t_req r;
        int pick;
        r.idx = 3'($urandom_range(7));
        r.data = 8'($urandom_range(255));
        r.addr = 15'($urandom_range(32767));
        r.flags = 3'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 40) r.cmd = ppu_rvp_pkg::CMD_REG_WR;
        else if (pick < 62) r.cmd = ppu_rvp_pkg::CMD_REG_RD;
        else if (pick < 67) r.cmd = ppu_rvp_pkg::CMD_OAM_LOAD;
        else if (pick < 82) r.cmd = ppu_rvp_pkg::CMD_VRAM_LOAD;
        else if (pick < 88) r.cmd = ppu_rvp_pkg::CMD_FRAME_START;
        else if (pick < 96) r.cmd = ppu_rvp_pkg::CMD_RAISE_STATUS;
        else r.cmd = 3'($urandom_range(6, 7));
        // Keep most direct loads inside the mapped region so later reads find them.
        if (r.cmd == ppu_rvp_pkg::CMD_VRAM_LOAD && $urandom_range(3) != 0) r.addr[14] = 1'b0;
        return r;
    endfunction

    t_row rows[] = '{
        '{ppu_rvp_pkg::CMD_REG_RD, ppu_rvp_pkg::REG_STATUS,
          8'h00, 15'h0000, 3'd0, 1'b1, 8'h00},
        '{ppu_rvp_pkg::CMD_REG_RD, ppu_rvp_pkg::REG_CTRL_A,
          8'h00, 15'h0000, 3'd0, 1'b1, 8'h00},
        '{ppu_rvp_pkg::CMD_REG_WR, ppu_rvp_pkg::REG_CTRL_A,
          8'h80, 15'h0000, 3'd0, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_RAISE_STATUS, ppu_rvp_pkg::REG_CTRL_A,
          8'h00, 15'h0000, 3'd7, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_REG_RD, ppu_rvp_pkg::REG_STATUS,
          8'h00, 15'h0000, 3'd0, 1'b1, 8'he0},
        '{ppu_rvp_pkg::CMD_REG_RD, ppu_rvp_pkg::REG_STATUS,
          8'h00, 15'h0000, 3'd0, 1'b1, 8'h60},
        '{ppu_rvp_pkg::CMD_REG_WR, ppu_rvp_pkg::REG_SCROLL,
          8'hff, 15'h0000, 3'd0, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_REG_WR, ppu_rvp_pkg::REG_SCROLL,
          8'h00, 15'h0000, 3'd0, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_REG_WR, ppu_rvp_pkg::REG_ADDR,
          8'hff, 15'h0000, 3'd0, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_REG_WR, ppu_rvp_pkg::REG_ADDR,
          8'h00, 15'h0000, 3'd0, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_REG_WR, ppu_rvp_pkg::REG_DATA,
          8'hff, 15'h0000, 3'd0, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_REG_WR, ppu_rvp_pkg::REG_ADDR,
          8'h3f, 15'h0000, 3'd0, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_REG_WR, ppu_rvp_pkg::REG_ADDR,
          8'h10, 15'h0000, 3'd0, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_REG_RD, ppu_rvp_pkg::REG_DATA,
          8'h00, 15'h0000, 3'd0, 1'b1, 8'h3f},
        '{ppu_rvp_pkg::CMD_VRAM_LOAD, ppu_rvp_pkg::REG_CTRL_A,
          8'hff, 15'h7fff, 3'd0, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_VRAM_LOAD, ppu_rvp_pkg::REG_CTRL_A,
          8'ha5, 15'h0000, 3'd0, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_REG_WR, ppu_rvp_pkg::REG_CTRL_A,
          8'h07, 15'h0000, 3'd0, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_REG_WR, ppu_rvp_pkg::REG_CTRL_B,
          8'h18, 15'h0000, 3'd0, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_FRAME_START, ppu_rvp_pkg::REG_CTRL_A,
          8'h00, 15'h0000, 3'd0, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_OAM_LOAD, ppu_rvp_pkg::REG_CTRL_A,
          8'h5a, 15'h7fff, 3'd0, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_REG_WR, ppu_rvp_pkg::REG_SPR_ADDR,
          8'hff, 15'h0000, 3'd0, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_REG_WR, ppu_rvp_pkg::REG_SPR_DATA,
          8'h00, 15'h0000, 3'd0, 1'b0, 8'h00},
        '{ppu_rvp_pkg::CMD_REG_WR, ppu_rvp_pkg::REG_STATUS,
          8'hff, 15'h0000, 3'd0, 1'b0, 8'h00},
        '{3'd6, ppu_rvp_pkg::REG_DATA,
          8'h00, 15'h0000, 3'd7, 1'b0, 8'h00},
        '{3'd7, ppu_rvp_pkg::REG_DATA,
          8'hff, 15'h7fff, 3'd7, 1'b0, 8'h00}
    };

    logic [2:0] modes [8] = '{ppu_rvp_pkg::MIRROR_SINGLE_LO, ppu_rvp_pkg::MIRROR_SINGLE_HI,
                              ppu_rvp_pkg::MIRROR_VERT, ppu_rvp_pkg::MIRROR_FOUR,
                              3'd5, 3'd6, 3'd7, ppu_rvp_pkg::MIRROR_HORZ};

    initial begin
        t_req r;
        int sent;
        int burst;
        p_mirror = ppu_rvp_pkg::MIRROR_RESET;
        p_v = '0; p_t = '0; p_fx = '0; p_toggle = 1'b0; p_buf = '0; p_status = '0;
        p_ctrl_a = '0; p_ctrl_b = '0; p_spr_addr = '0;
        foreach (p_pattern[i]) p_pattern[i] = '0;
        foreach (p_names[i]) p_names[i] = '0;
        foreach (p_palette[i]) p_palette[i] = '0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            r = '{rows[i].cmd, rows[i].idx, rows[i].data, rows[i].addr, rows[i].flags};
            send_request(r, rows[i].chk, rows[i].rd);
        end
        drop_valid();

        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            set_mirror(modes[ph]);
            quiet = (ph == 3);
            sent = 0;
            while (sent < RANDOM_ITEMS / 8) begin
                if ($urandom_range(99) < 35) begin
                    // Point v somewhere, then stream data through the data port.
                    r = '{ppu_rvp_pkg::CMD_REG_RD, ppu_rvp_pkg::REG_STATUS,
                          8'h00, 15'h0000, 3'd0};
                    send_request(r, 1'b0, 8'h00);
                    r.cmd = ppu_rvp_pkg::CMD_REG_WR;
                    r.idx = ppu_rvp_pkg::REG_ADDR;
                    r.data = $urandom_range(3) == 0 ? 8'h3f : 8'($urandom_range(255));
                    send_request(r, 1'b0, 8'h00);
                    r.data = 8'($urandom_range(255));
                    send_request(r, 1'b0, 8'h00);
                    burst = $urandom_range(2, 7);
                    for (int k = 0; k < burst; k++) begin
                        r.cmd = $urandom_range(1) ? ppu_rvp_pkg::CMD_REG_WR
                                                  : ppu_rvp_pkg::CMD_REG_RD;
                        r.idx = ppu_rvp_pkg::REG_DATA;
                        r.data = 8'($urandom_range(255));
                        send_request(r, 1'b0, 8'h00);
                    end
                    sent += burst + 3;
                end else begin
                    send_request(random_request(), 1'b0, 8'h00);
                    sent++;
                end
            end
            drop_valid();
        end

        quiet = 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
src/ppu_rvp_pkg.sv
src/ppu_rvp_front.sv
src/ppu_rvp_back.sv
src/ppu_register_vram_port.sv
tb/tb.sv
